/* rtl/core/rcmp_pkg.sv */
package rcmp_pkg;

    localparam int MAX_LENGTH = 1024;

    localparam int LEN_W    = 11;
    localparam int ADDR_W   = $clog2(MAX_LENGTH);
    localparam int PRICE_W  = 16;
    localparam int MEMO_W   = 27;
    localparam int PROFIT_W = 26;
    localparam int PIECE_W  = 3;
    localparam int IDX_W    = 3;
    localparam int NUM_PIECES = 4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_PRICE_LEN1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRICE_LEN2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_PRICE_LEN3 = 3'd2;
    localparam logic [IDX_W-1:0] REG_PRICE_LEN4 = 3'd3;

    // price reset values
    localparam logic [PRICE_W-1:0] PRICE_LEN1_RST = 16'd1;
    localparam logic [PRICE_W-1:0] PRICE_LEN2_RST = 16'd5;
    localparam logic [PRICE_W-1:0] PRICE_LEN3_RST = 16'd8;
    localparam logic [PRICE_W-1:0] PRICE_LEN4_RST = 16'd9;

    // piece codes
    localparam logic [PIECE_W-1:0] PIECE_NONE = 3'd0;
    localparam logic [PIECE_W-1:0] PIECE_LEN1 = 3'd1;
    localparam logic [PIECE_W-1:0] PIECE_LEN2 = 3'd2;
    localparam logic [PIECE_W-1:0] PIECE_LEN3 = 3'd3;
    localparam logic [PIECE_W-1:0] PIECE_LEN4 = 3'd4;

    typedef struct packed {
        logic take_len;     // latch the incoming rod length
        logic fill_step;    // compute and store one more table entry
        logic rd_en;        // read the table at the requested length
        logic load_table;   // output register <- table read data
        logic load_special; // output register <- zero-length / range-error result
    } ctrl_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic len_over;
        logic need_fill;
    } dp_stat_t;

endpackage

/* rtl/core/rcmp_ctrl.sv */
module rcmp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  rcmp_pkg::dp_stat_t stat,
    output rcmp_pkg::ctrl_cmd_t cmd
);
    import rcmp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FILL,
        S_LOAD,
        S_SPECIAL
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_len = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.len_zero || stat.len_over)
                    state_next = S_SPECIAL;
                else
                    state_next = S_FILL;
            end
            S_FILL:
            begin
                if (stat.need_fill)
                    cmd.fill_step = 1'b1;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_table = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SPECIAL:
            begin
                if (out_free)
                begin
                    cmd.load_special = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (cmd.load_table || cmd.load_special)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/rcmp_datapath.sv */
module rcmp_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rcmp_pkg::IDX_W-1:0]      cfg_addr,
    input  logic [rcmp_pkg::PRICE_W-1:0]    cfg_wdata,
    input  logic [rcmp_pkg::LEN_W-1:0]      rod_length,
    input  rcmp_pkg::ctrl_cmd_t             cmd,
    output rcmp_pkg::dp_stat_t              stat,
    output logic [rcmp_pkg::PROFIT_W-1:0]   best_profit,
    output logic [rcmp_pkg::PIECE_W-1:0]    first_piece,
    output logic                            out_of_range
);
    import rcmp_pkg::*;

    // price registers
    logic [PRICE_W-1:0] price_reg [NUM_PIECES];

    // request and fill progress
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_m1;
    logic [LEN_W-1:0]   filled_reg;

    // best(filled), best(filled-1), ... ; zero below length one
    logic [MEMO_W-1:0]  win_reg [NUM_PIECES];

    // memo table
    logic [MEMO_W-1:0]  profit_mem [MAX_LENGTH];
    logic [PIECE_W-1:0] piece_mem  [MAX_LENGTH];
    logic [MEMO_W-1:0]  rd_profit_reg;
    logic [PIECE_W-1:0] rd_piece_reg;

    // output register
    logic [PROFIT_W-1:0] best_profit_reg;
    logic [PIECE_W-1:0]  first_piece_reg;
    logic                oor_reg;

    // candidate selection
    logic [MEMO_W-1:0]  cand [NUM_PIECES];
    logic               cand_ok [NUM_PIECES];
    logic [MEMO_W-1:0]  best_a, best_b, best_new;
    logic [PIECE_W-1:0] piece_a, piece_b, piece_new;

    assign len_m1 = len_reg - LEN_W'(1);

    assign stat.len_zero  = (len_reg == '0);
    assign stat.len_over  = (len_reg > LEN_W'(MAX_LENGTH));
    assign stat.need_fill = (filled_reg < len_reg);

    always_comb
    begin
        for (int k = 0; k < NUM_PIECES; k++)
        begin
            cand[k]    = MEMO_W'(price_reg[k]) + win_reg[k];
            cand_ok[k] = (filled_reg >= LEN_W'(k));
        end

        // shorter piece wins ties
        if (cand_ok[1] && (cand[1] > cand[0]))
        begin
            best_a  = cand[1];
            piece_a = PIECE_LEN2;
        end
        else
        begin
            best_a  = cand[0];
            piece_a = PIECE_LEN1;
        end

        if (cand_ok[3] && (cand[3] > cand[2]))
        begin
            best_b  = cand[3];
            piece_b = PIECE_LEN4;
        end
        else
        begin
            best_b  = cand[2];
            piece_b = PIECE_LEN3;
        end

        if (cand_ok[2] && (best_b > best_a))
        begin
            best_new  = best_b;
            piece_new = piece_b;
        end
        else
        begin
            best_new  = best_a;
            piece_new = piece_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            price_reg[0] <= PRICE_LEN1_RST;
            price_reg[1] <= PRICE_LEN2_RST;
            price_reg[2] <= PRICE_LEN3_RST;
            price_reg[3] <= PRICE_LEN4_RST;
            filled_reg   <= '0;
            for (int k = 0; k < NUM_PIECES; k++)
                win_reg[k] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_PRICE_LEN1: price_reg[0] <= cfg_wdata;
                    REG_PRICE_LEN2: price_reg[1] <= cfg_wdata;
                    REG_PRICE_LEN3: price_reg[2] <= cfg_wdata;
                    REG_PRICE_LEN4: price_reg[3] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.fill_step)
            begin
                filled_reg <= filled_reg + LEN_W'(1);
                win_reg[0] <= best_new;
                for (int k = 1; k < NUM_PIECES; k++)
                    win_reg[k] <= win_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_len)
            len_reg <= rod_length;
        if (cmd.fill_step)
        begin
            profit_mem[filled_reg[ADDR_W-1:0]] <= best_new;
            piece_mem[filled_reg[ADDR_W-1:0]]  <= piece_new;
        end
        if (cmd.rd_en)
        begin
            rd_profit_reg <= profit_mem[len_m1[ADDR_W-1:0]];
            rd_piece_reg  <= piece_mem[len_m1[ADDR_W-1:0]];
        end
        if (cmd.load_table)
        begin
            best_profit_reg <= rd_profit_reg[PROFIT_W-1:0];
            first_piece_reg <= rd_piece_reg;
            oor_reg         <= 1'b0;
        end
        else if (cmd.load_special)
        begin
            best_profit_reg <= '0;
            first_piece_reg <= PIECE_NONE;
            oor_reg         <= stat.len_over;
        end
    end

    assign best_profit  = best_profit_reg;
    assign first_piece  = first_piece_reg;
    assign out_of_range = oor_reg;

endmodule

/* rtl/core/rod_cutting_max_profit_top.sv */
// Rod-cutting maximum profit with a memo table of best profit and first piece.
// Input channel (in_valid/in_ready, rod_length): one transfer per query.
// Output channel (out_valid/out_ready): best_profit, first_piece, out_of_range,
// exactly one result transfer per query, in order.
// Config port: cfg_we/cfg_addr/cfg_wdata write the four piece prices; write
// only while the block is idle. Index above 3 is dropped.
// Steps from input transfer to out_valid: check, table fill for each new length
// the table must be extended by, table read, load; a zero or out-of-range
// length goes check, special load. Each load waits for the output register to
// free. The fill unit computes one table entry per cycle.
// One query is in flight at a time; in_ready is high only when idle. A new
// query is taken only once the result of the last one has loaded.
// The result waits in the output register while out_ready is low; the next
// input transfer is still taken, and its result loads once the register frees.
// Reset: prices return to 1, 5, 8, 9 and the table is empty (filled length 0);
// no clearing pass, entries are written before they are ever read.
module rod_cutting_max_profit_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // config write port
    input  logic                          cfg_we,
    input  logic [rcmp_pkg::IDX_W-1:0]    cfg_addr,
    input  logic [rcmp_pkg::PRICE_W-1:0]  cfg_wdata,
    // query channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rcmp_pkg::LEN_W-1:0]    rod_length,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rcmp_pkg::PROFIT_W-1:0] best_profit,
    output logic [rcmp_pkg::PIECE_W-1:0]  first_piece,
    output logic                          out_of_range
);
    import rcmp_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: query flow and output-register occupancy
    rcmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // prices, fill unit, memo table, output register
    rcmp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .rod_length   (rod_length),
        .cmd          (cmd),
        .stat         (stat),
        .best_profit  (best_profit),
        .first_piece  (first_piece),
        .out_of_range (out_of_range)
    );

    // A range error carries no profit and no piece.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (best_profit == '0 && first_piece == PIECE_NONE))
        else $error("range error result carries data");

    // No result, table hit or special, shows a piece code above four.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (first_piece <= PIECE_LEN4))
        else $error("illegal first piece");

    // Only one query in flight: after an input transfer the port closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second query taken while busy");

    // The fill unit only runs with a query in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_step |-> !in_ready)
        else $error("fill step while idle");

endmodule

/* tb/rod_cutting_max_profit_top_tb.sv */
module rod_cutting_max_profit_top_tb;
    import rcmp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 3;
    // Hard stop, far beyond the slowest legal run.
    localparam int RUN_LIMIT    = 200000 * 2 * CLK_HALF;
    // Quiet cycles after the last result, to catch any stray result.
    localparam int TAIL_CYCLES  = 24;
    localparam int NUM_SEGMENTS = 11;
    localparam int SEG_QUERIES  = 50;
    localparam int MIN_CEILING  = 16;
    localparam int MAX_REPORTS  = 10;

    localparam logic [PRICE_W-1:0] PRICE_ZERO = '0;
    localparam logic [PRICE_W-1:0] PRICE_MAX  = '1;

    // One expected result transfer.
    typedef struct {
        bit [PROFIT_W-1:0] profit;
        bit [PIECE_W-1:0]  piece;
        bit                over;
    } cut_result_t;

    // Scoreboard: keeps its own copy of the prices and the memo table, and
    // predicts each result when the query transfer is accepted.
    class cut_plan_checker;
        bit [PRICE_W-1:0] price [NUM_PIECES];
        bit [MEMO_W-1:0]  profit_tab [MAX_LENGTH];
        bit [PIECE_W-1:0] piece_tab [MAX_LENGTH];
        int               filled_len;
        int               mismatches;
        cut_result_t      expected_cuts [$];

        function new();
            price[0]   = PRICE_LEN1_RST;
            price[1]   = PRICE_LEN2_RST;
            price[2]   = PRICE_LEN3_RST;
            price[3]   = PRICE_LEN4_RST;
            filled_len = 0;
            mismatches = 0;
        endfunction

        function void set_price(logic [IDX_W-1:0] idx, logic [PRICE_W-1:0] val);
            case (idx)
                REG_PRICE_LEN1: price[0] = val;
                REG_PRICE_LEN2: price[1] = val;
                REG_PRICE_LEN3: price[2] = val;
                REG_PRICE_LEN4: price[3] = val;
                default: ;
            endcase
        endfunction

        // Grow the table one length at a time; ties keep the shorter piece.
        function void extend_table(int len);
            bit [MEMO_W:0]    best;
            bit [MEMO_W:0]    cand;
            bit [MEMO_W-1:0]  rest;
            bit [PIECE_W-1:0] piece;
            for (int m = filled_len + 1; m <= len; m++)
            begin
                best  = '0;
                piece = PIECE_NONE;
                for (int k = 1; k <= NUM_PIECES && k <= m; k++)
                begin
                    rest = (m == k) ? '0 : profit_tab[m-k-1];
                    cand = price[k-1] + rest;
                    if (piece == PIECE_NONE || cand > best)
                    begin
                        best  = cand;
                        piece = PIECE_W'(k);
                    end
                end
                profit_tab[m-1] = best[MEMO_W-1:0];
                piece_tab[m-1]  = piece;
            end
            if (len > filled_len)
                filled_len = len;
        endfunction

        function void note_query(logic [LEN_W-1:0] len);
            cut_result_t exp_r;
            exp_r.profit = '0;
            exp_r.piece  = PIECE_NONE;
            exp_r.over   = 1'b0;
            if (len > MAX_LENGTH)
                exp_r.over = 1'b1;
            else if (len != 0)
            begin
                extend_table(len);
                exp_r.profit = profit_tab[len-1][PROFIT_W-1:0];
                exp_r.piece  = piece_tab[len-1];
            end
            expected_cuts.push_back(exp_r);
        endfunction

        function void check_result(logic [PROFIT_W-1:0] profit,
                                   logic [PIECE_W-1:0] piece, logic over);
            cut_result_t exp_r;
            if (expected_cuts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: profit %0d piece %0d over %0b",
                             profit, piece, over);
                return;
            end
            exp_r = expected_cuts.pop_front();
            if (profit !== exp_r.profit || piece !== exp_r.piece || over !== exp_r.over)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: exp profit %0d piece %0d over %0b, got %0d %0d %0b",
                             exp_r.profit, exp_r.piece, exp_r.over, profit, piece, over);
            end
        endfunction

        function int pending();
            return expected_cuts.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_addr;
    logic [PRICE_W-1:0]  cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic [LEN_W-1:0]    rod_length;
    logic                out_valid;
    logic                out_ready;
    logic [PROFIT_W-1:0] best_profit;
    logic [PIECE_W-1:0]  first_piece;
    logic                out_of_range;

    cut_plan_checker board = new();

    // Idle rates in percent; changed as the random part moves on.
    int send_idle_pct = 16;
    int recv_idle_pct = 51;

    rod_cutting_max_profit_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rod_length   (rod_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .best_profit  (best_profit),
        .first_piece  (first_piece),
        .out_of_range (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #RUN_LIMIT;
        $display("Verification failed");
        $finish;
    end

    // Receiver: back-pressure is redrawn at every falling edge.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor: every result transfer is checked against the oldest
    // prediction.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_result(best_profit, first_piece, out_of_range);
        end
    end

    // Present one query; valid holds until the transfer, then the model is
    // updated at the accepting edge.
    task automatic send_query(input logic [LEN_W-1:0] len);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        rod_length = len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_query(len);
    endtask

    // Sender stops until every predicted result has come back and the
    // block is ready for a new query.
    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending() != 0 || !in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PRICE_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        board.set_price(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // New price set; only lengths filled from here on see it.
    task automatic set_prices(input logic [PRICE_W-1:0] p1, input logic [PRICE_W-1:0] p2,
                              input logic [PRICE_W-1:0] p3, input logic [PRICE_W-1:0] p4);
        wait_drain();
        write_reg(REG_PRICE_LEN1, p1);
        write_reg(REG_PRICE_LEN2, p2);
        write_reg(REG_PRICE_LEN3, p3);
        write_reg(REG_PRICE_LEN4, p4);
    endtask

    // Lengths near the filled edge so the table grows in steps across price changes,
    // the ceiling, any length up to it (old entries too), zeros, out of range.
    function automatic logic [LEN_W-1:0] pick_length(int ceiling);
        int unsigned r;
        int          len;
        r = $urandom_range(99);
        if (r < 8)
            len = 0;
        else if (r < 18)
            len = $urandom_range((1 << LEN_W) - 1, MAX_LENGTH + 1);
        else if (r < 23)
            len = ceiling;
        else if (r < 55)
        begin
            len = board.filled_len + $urandom_range(6, 1);
            if (len > ceiling)
                len = ceiling;
        end
        else
            len = $urandom_range(ceiling, 1);
        return LEN_W'(len);
    endfunction

    // Price set per segment: a rotation of full-range, small, tie-heavy
    // linear, all-extreme and byte-sized values.
    task automatic pick_prices(input int seg);
        logic [PRICE_W-1:0] p [NUM_PIECES];
        int unsigned        step;
        step = $urandom_range(PRICE_MAX / NUM_PIECES, 1);
        for (int k = 0; k < NUM_PIECES; k++)
        begin
            case (seg % 5)
                0: p[k] = PRICE_W'($urandom_range(PRICE_MAX));
                1: p[k] = PRICE_W'($urandom_range(15));
                2: p[k] = PRICE_W'(step * (k + 1));
                3: p[k] = $urandom_range(1) ? PRICE_MAX : PRICE_ZERO;
                default: p[k] = PRICE_W'($urandom_range(255));
            endcase
        end
        set_prices(p[0], p[1], p[2], p[3]);
    endtask

    initial
    begin
        int query_count;
        int ceiling;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = REG_PRICE_LEN1;
        cfg_wdata  = PRICE_ZERO;
        in_valid   = 1'b0;
        rod_length = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset prices, empty rod, first lengths, the two kinds of
        // out-of-range (just over and all ones).
        for (int len = 0; len <= 8; len++)
            send_query(LEN_W'(len));
        send_query(LEN_W'(MAX_LENGTH + 1));
        send_query('1);

        // Linear prices tie on every split: shorter piece must win. Lengths
        // already filled keep their old values.
        set_prices(16'd3, 16'd6, 16'd9, 16'd12);
        for (int len = 9; len <= 12; len++)
            send_query(LEN_W'(len));
        send_query(LEN_W'(3));
        send_query(LEN_W'(8));

        // Writes to indexes past the price registers are dropped.
        wait_drain();
        for (int idx = NUM_PIECES; idx < (1 << IDX_W); idx++)
            write_reg(IDX_W'(idx), PRICE_MAX);
        send_query(LEN_W'(13));
        send_query(LEN_W'(14));

        // Extreme price sets.
        set_prices(PRICE_ZERO, PRICE_ZERO, PRICE_ZERO, PRICE_ZERO);
        send_query(LEN_W'(15));
        send_query(LEN_W'(16));
        set_prices(PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX);
        send_query(LEN_W'(17));
        send_query(LEN_W'(19));

        // Random: the ceiling rises segment by segment up to the full table,
        // each segment under its own prices. Idling: sender light and
        // receiver heavy, then swapped, then none.
        query_count = 0;
        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            pick_prices(seg);
            ceiling = MIN_CEILING + seg * (MAX_LENGTH - MIN_CEILING) / (NUM_SEGMENTS - 1);
            for (int i = 0; i < SEG_QUERIES; i++)
            begin
                if (query_count == NUM_SEGMENTS * SEG_QUERIES / 3)
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 16;
                end
                else if (query_count == 2 * NUM_SEGMENTS * SEG_QUERIES / 3)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_query(pick_length(ceiling));
                query_count++;
            end
        end
        send_query(LEN_W'(MAX_LENGTH));

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        // Predictions never matched by a result count as failures.
        board.mismatches += board.pending();
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
